FILE: src/i2c_target_message_mailbox_defines.svh
// assertion macros for the i2c target message mailbox
`ifndef I2C_TARGET_MESSAGE_MAILBOX_DEFINES_SVH
`define I2C_TARGET_MESSAGE_MAILBOX_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define I2CTM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define I2CTM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/i2ctm_pkg.sv
// shared codes and types of the i2c target message mailbox
`timescale 1ns / 1ps
`default_nettype none

package i2ctm_pkg;

   // bus event codes
   localparam logic [2:0] ACT_WRITE_START = 3'd0;
   localparam logic [2:0] ACT_WRITE_BYTE  = 3'd1;
   localparam logic [2:0] ACT_READ_START  = 3'd2;
   localparam logic [2:0] ACT_READ_NEXT   = 3'd3;
   localparam logic [2:0] ACT_STOP        = 3'd4;
   localparam logic [2:0] ACT_LOAD_BYTE   = 3'd5;

   // register pointer values
   localparam logic [7:0] PTR_UNSET    = 8'h00;
   localparam logic [7:0] PTR_IDENT    = 8'h01;
   localparam logic [7:0] PTR_OUT_FIFO = 8'h10;
   localparam logic [7:0] PTR_LEN_LOW  = 8'h11;
   localparam logic [7:0] PTR_LEN_HIGH = 8'h12;
   localparam logic [7:0] PTR_IN_FIFO  = 8'h20;
   localparam logic [7:0] PTR_INVALID  = 8'hFE;

   localparam logic [7:0] IDENT_VALUE = 8'h50;

   // response status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NACK = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // one bus event as held in the execute stage
   typedef struct packed {
      logic       load_last;
      logic [7:0] data;
      logic [2:0] action;
   } req_type;

endpackage

`default_nettype wire

FILE: src/i2c_target_message_mailbox.sv
// i2c target message mailbox: register map over bus events, outgoing queue, input fifo
// a request passes the execute stage, then the result register, which gives its response
// one request per cycle unless responses stall; byte ram read prefetched from next state
// the message byte ram has one registered read port addressed by head slot and out index
// reset (synchronous, active high) clears pointer, counters, queue control and valid flags
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_target_message_mailbox_defines.svh"

module i2c_target_message_mailbox #(
   parameter int QUEUE_DEPTH   = 4,
   parameter int MSG_BYTES     = 32,
   parameter int IN_FIFO_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // action [2:0], data [10:3], zero fill [15:11]
   input  wire logic        req_tlast,   // load_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // read_data [7:0], status [9:8], zero fill [15:10]
);

   localparam int HW   = $clog2(QUEUE_DEPTH);
   localparam int UW   = $clog2(QUEUE_DEPTH + 1);
   localparam int IW   = $clog2(MSG_BYTES + 1);
   localparam int CW   = $clog2(IN_FIFO_BYTES + 1);
   localparam int IAW  = $clog2(IN_FIFO_BYTES);
   localparam int BD   = QUEUE_DEPTH * MSG_BYTES;
   localparam int BAW  = $clog2(BD);

   // execute stage
   logic               stage_valid_ff, stage_valid_in;
   i2ctm_pkg::req_type stage_ff;
   logic               exec;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rd_ff, rd_in;
   logic [1:0]         status_ff, status_in;

   // mailbox state
   logic [7:0]         ptr_ff, ptr_in;
   logic [CW-1:0]      in_count_ff, in_count_in;
   logic [IW-1:0]      out_index_ff, out_index_in;
   logic               held_ff, held_in;
   logic [HW-1:0]      head_ff, head_in;
   logic [UW-1:0]      used_ff, used_in;
   logic [IW-1:0]      load_index_ff, load_index_in;
   logic [IW-1:0]      lengths_ff [QUEUE_DEPTH];

   // write side controls
   logic               in_wr_en;
   logic               q_wr_en;
   logic [BAW-1:0]     q_wr_addr;
   logic [BAW-1:0]     q_rd_addr;
   logic [7:0]         q_rd_data;
   logic               len_wr_en;
   logic [HW-1:0]      len_wr_slot;

   // derived values
   logic [UW:0]        slot_sum;
   logic [HW-1:0]      tail_slot;
   logic [HW:0]        head_inc;
   logic [HW-1:0]      head_next;
   logic [IW-1:0]      head_len;
   logic [15:0]        head_len_wide;
   logic [IW-1:0]      load_index_post;
   logic [IW-1:0]      out_index_post;
   logic               held_eff;

   assign exec       = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || exec;

   // tail slot and head advance, modulo queue depth
   always_comb begin
      slot_sum = (UW + 1)'(head_ff) + (UW + 1)'(used_ff);
      if (slot_sum >= (UW + 1)'(QUEUE_DEPTH)) begin
         slot_sum = slot_sum - (UW + 1)'(QUEUE_DEPTH);
      end
      tail_slot = HW'(slot_sum);
      head_inc  = (HW + 1)'(head_ff) + (HW + 1)'(1);
      if (head_inc == (HW + 1)'(QUEUE_DEPTH)) begin
         head_inc = '0;
      end
      head_next = HW'(head_inc);
   end

   assign head_len      = lengths_ff[head_ff];
   assign head_len_wide = 16'(head_len);

   // event execution
   always_comb begin
      ptr_in          = ptr_ff;
      in_count_in     = in_count_ff;
      out_index_in    = out_index_ff;
      held_in         = held_ff;
      head_in         = head_ff;
      used_in         = used_ff;
      load_index_in   = load_index_ff;
      rd_in           = 8'h00;
      status_in       = i2ctm_pkg::ST_OK;
      in_wr_en        = 1'b0;
      q_wr_en         = 1'b0;
      len_wr_en       = 1'b0;
      len_wr_slot     = tail_slot;
      load_index_post = load_index_ff;
      out_index_post  = out_index_ff;
      held_eff        = held_ff;
      q_wr_addr       = BAW'(tail_slot) * BAW'(MSG_BYTES) + BAW'(load_index_ff);

      if (exec) begin
         case (stage_ff.action)
            i2ctm_pkg::ACT_WRITE_START: begin
               if (ptr_ff != i2ctm_pkg::PTR_UNSET && ptr_ff != i2ctm_pkg::PTR_IN_FIFO) begin
                  status_in = i2ctm_pkg::ST_NACK;
               end
            end
            i2ctm_pkg::ACT_WRITE_BYTE: begin
               if (ptr_ff == i2ctm_pkg::PTR_UNSET) begin
                  ptr_in = stage_ff.data;
               end else if (ptr_ff == i2ctm_pkg::PTR_IN_FIFO) begin
                  if (in_count_ff < CW'(IN_FIFO_BYTES)) begin
                     in_wr_en    = 1'b1;
                     in_count_in = in_count_ff + CW'(1);
                  end else begin
                     ptr_in    = i2ctm_pkg::PTR_INVALID;
                     status_in = i2ctm_pkg::ST_FULL;
                  end
               end else begin
                  status_in = i2ctm_pkg::ST_NACK;
               end
            end
            i2ctm_pkg::ACT_READ_START, i2ctm_pkg::ACT_READ_NEXT: begin
               // a read start at the length register latches the head message
               if (stage_ff.action == i2ctm_pkg::ACT_READ_START &&
                   ptr_ff == i2ctm_pkg::PTR_LEN_LOW) begin
                  held_eff = (used_ff != '0);
                  held_in  = held_eff;
               end
               case (ptr_ff)
                  i2ctm_pkg::PTR_IDENT: begin
                     rd_in  = i2ctm_pkg::IDENT_VALUE;
                     ptr_in = i2ctm_pkg::PTR_INVALID;
                  end
                  i2ctm_pkg::PTR_OUT_FIFO: begin
                     if (!held_eff) begin
                        status_in = i2ctm_pkg::ST_NACK;
                     end else begin
                        if (out_index_ff < head_len && out_index_ff < IW'(MSG_BYTES)) begin
                           rd_in          = q_rd_data;
                           out_index_post = out_index_ff + IW'(1);
                           out_index_in   = out_index_post;
                        end
                        if (out_index_post >= head_len) begin
                           ptr_in = i2ctm_pkg::PTR_INVALID;
                        end
                     end
                  end
                  i2ctm_pkg::PTR_LEN_LOW: begin
                     if (held_eff) begin
                        rd_in = head_len_wide[7:0];
                     end
                     ptr_in = i2ctm_pkg::PTR_LEN_HIGH;
                  end
                  i2ctm_pkg::PTR_LEN_HIGH: begin
                     if (held_eff) begin
                        rd_in = head_len_wide[15:8];
                     end
                     ptr_in = i2ctm_pkg::PTR_INVALID;
                  end
                  default: begin
                     status_in = i2ctm_pkg::ST_NACK;
                  end
               endcase
            end
            i2ctm_pkg::ACT_STOP: begin
               ptr_in = i2ctm_pkg::PTR_UNSET;
               // release the held message once any byte of it was streamed
               if (out_index_ff != '0) begin
                  out_index_in = '0;
                  held_in      = 1'b0;
                  if (used_ff != '0) begin
                     head_in = head_next;
                     used_in = used_ff - UW'(1);
                  end
               end
            end
            i2ctm_pkg::ACT_LOAD_BYTE: begin
               if (used_ff >= UW'(QUEUE_DEPTH)) begin
                  status_in = i2ctm_pkg::ST_FULL;
               end else begin
                  if (load_index_ff < IW'(MSG_BYTES)) begin
                     q_wr_en         = 1'b1;
                     load_index_post = load_index_ff + IW'(1);
                     load_index_in   = load_index_post;
                  end else begin
                     status_in = i2ctm_pkg::ST_FULL;
                  end
                  if (stage_ff.load_last) begin
                     len_wr_en     = 1'b1;
                     used_in       = used_ff + UW'(1);
                     load_index_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // prefetch the streamed byte for the state the next request will see
   assign q_rd_addr = BAW'(head_in) * BAW'(MSG_BYTES) + BAW'(out_index_in);

   // outgoing message bytes
   i2ctm_ram #(
      .WIDTH (8),
      .DEPTH (BD)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (stage_ff.data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   // input fifo bytes; the read port is unused and the count is never lowered
   i2ctm_ram #(
      .WIDTH (8),
      .DEPTH (IN_FIFO_BYTES)
   ) u_in_ram (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_count_ff[IAW-1:0]),
      .wr_data (stage_ff.data),
      .rd_addr ('0),
      .rd_data ()
   );

   // message length per queue slot
   always_ff @(posedge clock) begin
      if (len_wr_en) begin
         lengths_ff[len_wr_slot] <= load_index_post;
      end
   end

   // stage and result handshake
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
      end else if (exec) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ptr_ff         <= i2ctm_pkg::PTR_UNSET;
         in_count_ff    <= '0;
         out_index_ff   <= '0;
         held_ff        <= 1'b0;
         head_ff        <= '0;
         used_ff        <= '0;
         load_index_ff  <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         ptr_ff         <= ptr_in;
         in_count_ff    <= in_count_in;
         out_index_ff   <= out_index_in;
         held_ff        <= held_in;
         head_ff        <= head_in;
         used_ff        <= used_in;
         load_index_ff  <= load_index_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff.action    <= req_tdata[2:0];
         stage_ff.data      <= req_tdata[10:3];
         stage_ff.load_last <= req_tlast;
      end
      if (exec) begin
         rd_ff     <= rd_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, status_ff, rd_ff};

   // checks
   `I2CTM_ASSERT_SAME(a_used_bound, 1'b1, used_ff <= UW'(QUEUE_DEPTH),
      "queue use count above depth")
   `I2CTM_ASSERT_SAME(a_held_needs_msg, held_ff, used_ff != '0,
      "message held with empty queue")
   `I2CTM_ASSERT_SAME(a_in_count_bound, 1'b1, in_count_ff <= CW'(IN_FIFO_BYTES),
      "input fifo count above size")
   `I2CTM_ASSERT_NEXT(a_stall_keeps_stage, stage_valid_ff && rsp_valid_ff && !rsp_tready,
      stage_valid_ff, "pending request lost while response stalled")

endmodule

`default_nettype wire

FILE: src/i2ctm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module i2ctm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: tb/tb_i2c_target_message_mailbox.sv
// testbench for the i2c target message mailbox: directed table plus random bus events
`timescale 1ns / 1ps

module tb_i2c_target_message_mailbox;

   localparam int QDEPTH         = 4;
   localparam int MSG_MAX        = 32;
   localparam int IN_MAX         = 32;
   localparam int RANDOM_EVENTS  = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   // event codes the block ignores
   localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [7:0] rd;
      logic [1:0] st;
   } mbx_resp_type;

   typedef struct packed {
      logic [2:0] act;
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [7:0] rd;
      logic [1:0] st;
   } dir_row_type;

   localparam int DIR_ROWS = 27;

   // directed table: event, data, load_last, typed flag, typed read_data, typed status
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{i2ctm_pkg::ACT_READ_NEXT,   8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_NACK},
      '{ACT_UNUSED_6,               8'hFF, 1'b1, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{ACT_UNUSED_7,               8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_START, 8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_BYTE,  i2ctm_pkg::PTR_IDENT, 1'b0, 1'b1, 8'h00,
        i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_READ_START,  8'h00, 1'b0, 1'b1, i2ctm_pkg::IDENT_VALUE,
        i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_READ_NEXT,   8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_NACK},
      '{i2ctm_pkg::ACT_WRITE_START, 8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_NACK},
      '{i2ctm_pkg::ACT_WRITE_BYTE,  8'hFF, 1'b1, 1'b1, 8'h00, i2ctm_pkg::ST_NACK},
      '{i2ctm_pkg::ACT_STOP,        8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_START, 8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_BYTE,  i2ctm_pkg::PTR_LEN_LOW, 1'b0, 1'b1, 8'h00,
        i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_READ_START,  8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_STOP,        8'h00, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_LOAD_BYTE,   8'hFF, 1'b0, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_LOAD_BYTE,   8'h00, 1'b1, 1'b1, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_START, 8'h00, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_BYTE,  i2ctm_pkg::PTR_LEN_LOW, 1'b0, 1'b0, 8'h00,
        i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_READ_START,  8'h00, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_READ_NEXT,   8'h00, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_STOP,        8'h00, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_BYTE,  i2ctm_pkg::PTR_OUT_FIFO, 1'b0, 1'b0, 8'h00,
        i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_READ_START,  8'h00, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_READ_NEXT,   8'h00, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_STOP,        8'h00, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_BYTE,  i2ctm_pkg::PTR_IN_FIFO, 1'b0, 1'b0, 8'h00,
        i2ctm_pkg::ST_OK},
      '{i2ctm_pkg::ACT_WRITE_BYTE,  8'hA5, 1'b0, 1'b0, 8'h00, i2ctm_pkg::ST_OK}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = 16'h0000;   // action [2:0], data [10:3], zero fill [15:11]
   logic        req_tlast   = 1'b0;       // load_last
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;                // read_data [7:0], status [9:8], zero fill [15:10]

   // mailbox state as the predictor sees it
   logic [7:0]  mb_ptr;
   int unsigned mb_in_count;
   int unsigned mb_out_idx;
   bit          mb_held;
   byte unsigned mb_msg_bytes [QDEPTH*MSG_MAX];
   int unsigned mb_msg_len [QDEPTH];
   int unsigned mb_head;
   int unsigned mb_used;
   int unsigned mb_load_idx;

   mbx_resp_type pending_resp [$];
   int          mismatches   = 0;
   int          idle_cycles  = 0;
   int          items_sent   = 0;
   bit          gaps_on      = 1'b0;
   bit          stall_on     = 1'b0;
   int          rsp_hold     = 0;

   i2c_target_message_mailbox dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 2);
   endfunction

   // register read side effects of the mailbox
   function automatic void mailbox_read(output logic [7:0] rd, output logic [1:0] st);
      int unsigned msg_len;
      rd = 8'h00;
      st = i2ctm_pkg::ST_OK;
      msg_len = mb_msg_len[mb_head];
      case (mb_ptr)
         i2ctm_pkg::PTR_IDENT: begin
            rd = i2ctm_pkg::IDENT_VALUE;
            mb_ptr = i2ctm_pkg::PTR_INVALID;
         end
         i2ctm_pkg::PTR_OUT_FIFO: begin
            if (!mb_held) begin
               st = i2ctm_pkg::ST_NACK;
            end else begin
               if (mb_out_idx < msg_len && mb_out_idx < MSG_MAX) begin
                  rd = mb_msg_bytes[mb_head*MSG_MAX + mb_out_idx];
                  mb_out_idx++;
               end
               if (mb_out_idx >= msg_len) mb_ptr = i2ctm_pkg::PTR_INVALID;
            end
         end
         i2ctm_pkg::PTR_LEN_LOW: begin
            if (mb_held) rd = msg_len[7:0];
            mb_ptr = i2ctm_pkg::PTR_LEN_HIGH;
         end
         i2ctm_pkg::PTR_LEN_HIGH: begin
            if (mb_held) rd = 8'(msg_len >> 8);
            mb_ptr = i2ctm_pkg::PTR_INVALID;
         end
         default: st = i2ctm_pkg::ST_NACK;
      endcase
   endfunction

   // response to one bus event, advancing the mailbox state
   function automatic mbx_resp_type mailbox_event(input logic [2:0] act,
                                                  input logic [7:0] data,
                                                  input logic last);
      mbx_resp_type resp;
      int unsigned  slot;
      resp = '0;
      case (act)
         i2ctm_pkg::ACT_WRITE_START: begin
            if (mb_ptr != i2ctm_pkg::PTR_UNSET && mb_ptr != i2ctm_pkg::PTR_IN_FIFO) begin
               resp.st = i2ctm_pkg::ST_NACK;
            end
         end
         i2ctm_pkg::ACT_WRITE_BYTE: begin
            if (mb_ptr == i2ctm_pkg::PTR_UNSET) begin
               mb_ptr = data;
            end else if (mb_ptr == i2ctm_pkg::PTR_IN_FIFO) begin
               if (mb_in_count < IN_MAX) begin
                  mb_in_count++;
               end else begin
                  mb_ptr = i2ctm_pkg::PTR_INVALID;
                  resp.st = i2ctm_pkg::ST_FULL;
               end
            end else begin
               resp.st = i2ctm_pkg::ST_NACK;
            end
         end
         i2ctm_pkg::ACT_READ_START: begin
            if (mb_ptr == i2ctm_pkg::PTR_LEN_LOW) mb_held = (mb_used > 0);
            mailbox_read(resp.rd, resp.st);
         end
         i2ctm_pkg::ACT_READ_NEXT: mailbox_read(resp.rd, resp.st);
         i2ctm_pkg::ACT_STOP: begin
            mb_ptr = i2ctm_pkg::PTR_UNSET;
            if (mb_out_idx != 0) begin
               mb_out_idx = 0;
               mb_held = 1'b0;
               if (mb_used > 0) begin
                  mb_head = (mb_head + 1) % QDEPTH;
                  mb_used--;
               end
            end
         end
         i2ctm_pkg::ACT_LOAD_BYTE: begin
            if (mb_used >= QDEPTH) begin
               resp.st = i2ctm_pkg::ST_FULL;
            end else begin
               slot = (mb_head + mb_used) % QDEPTH;
               if (mb_load_idx < MSG_MAX) begin
                  mb_msg_bytes[slot*MSG_MAX + mb_load_idx] = data;
                  mb_load_idx++;
               end else begin
                  resp.st = i2ctm_pkg::ST_FULL;
               end
               if (last) begin
                  mb_msg_len[slot] = mb_load_idx;
                  mb_used++;
                  mb_load_idx = 0;
               end
            end
         end
         default: ;
      endcase
      return resp;
   endfunction

   // drive one request, wait for its handshake, then record what it should return
   task automatic send_event(input logic [2:0] act, input logic [7:0] data, input logic last,
                             input logic typed, input mbx_resp_type typed_resp);
      int           gap;
      mbx_resp_type predicted;
      gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b00000, data, act};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predicted = mailbox_event(act, data, last);
      pending_resp.push_back(typed ? typed_resp : predicted);
      if (act <= i2ctm_pkg::ACT_LOAD_BYTE) items_sent++;
   endtask

   task automatic bus_event(input logic [2:0] act, input logic [7:0] data, input logic last);
      send_event(act, data, last, 1'b0, '0);
   endtask

   // outgoing message of random length and content
   task automatic load_message();
      int n_bytes;
      n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      for (int i = 0; i < n_bytes; i++)
         bus_event(i2ctm_pkg::ACT_LOAD_BYTE, 8'($urandom), i == n_bytes - 1);
   endtask

   // length read then streaming of the held message
   task automatic fetch_message();
      int n_reads;
      n_reads = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 5);
      bus_event(i2ctm_pkg::ACT_WRITE_START, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_WRITE_BYTE, i2ctm_pkg::PTR_LEN_LOW, 1'($urandom));
      bus_event(i2ctm_pkg::ACT_READ_START, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 1)) bus_event(i2ctm_pkg::ACT_READ_NEXT, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_STOP, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_WRITE_START, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_WRITE_BYTE, i2ctm_pkg::PTR_OUT_FIFO, 1'($urandom));
      bus_event(i2ctm_pkg::ACT_READ_START, 8'($urandom), 1'($urandom));
      for (int i = 0; i < n_reads; i++)
         bus_event(i2ctm_pkg::ACT_READ_NEXT, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_STOP, 8'($urandom), 1'($urandom));
   endtask

   task automatic read_identity();
      bus_event(i2ctm_pkg::ACT_WRITE_START, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_WRITE_BYTE, i2ctm_pkg::PTR_IDENT, 1'($urandom));
      bus_event(i2ctm_pkg::ACT_READ_START, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 2) == 0)
         bus_event(i2ctm_pkg::ACT_READ_NEXT, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_STOP, 8'($urandom), 1'($urandom));
   endtask

   // bytes into the input fifo, which never drains
   task automatic write_in_fifo();
      int n_bytes;
      n_bytes = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 4);
      bus_event(i2ctm_pkg::ACT_WRITE_START, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_WRITE_BYTE, i2ctm_pkg::PTR_IN_FIFO, 1'($urandom));
      for (int i = 0; i < n_bytes; i++)
         bus_event(i2ctm_pkg::ACT_WRITE_BYTE, 8'($urandom), 1'($urandom));
      bus_event(i2ctm_pkg::ACT_STOP, 8'($urandom), 1'($urandom));
   endtask

   // unstructured events, often leaving a transaction half done
   task automatic noise_burst();
      int n_events;
      n_events = $urandom_range(1, 4);
      for (int i = 0; i < n_events; i++)
         bus_event(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 1)) bus_event(i2ctm_pkg::ACT_STOP, 8'($urandom), 1'($urandom));
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
         rsp_hold   <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      mbx_resp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_resp.size() == 0) begin
            report_mismatch("response with no request pending", rsp_tdata, 0);
         end else begin
            want = pending_resp.pop_front();
            if (rsp_tdata[7:0] != want.rd) report_mismatch("read_data", rsp_tdata[7:0], want.rd);
            if (rsp_tdata[9:8] != want.st) report_mismatch("status", rsp_tdata[9:8], want.st);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL i2c_target_message_mailbox");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      mb_ptr      = i2ctm_pkg::PTR_UNSET;
      mb_in_count = 0;
      mb_out_idx  = 0;
      mb_held     = 1'b0;
      mb_head     = 0;
      mb_used     = 0;
      mb_load_idx = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++)
         send_event(dir_rows[r].act, dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed,
                    '{rd: dir_rows[r].rd, st: dir_rows[r].st});

      // random sequences, mostly well formed
      items_sent = 0;
      while (items_sent < RANDOM_EVENTS) begin
         gaps_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 3) load_message();
         else if (pick < 6) fetch_message();
         else if (pick < 7) read_identity();
         else if (pick < 8) write_in_fifo();
         else noise_burst();
      end
      req_tvalid <= 1'b0;

      // drain
      stall_on = 1'b0;
      while (pending_resp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS i2c_target_message_mailbox");
      end else begin
         $display("FAIL i2c_target_message_mailbox");
      end
      $finish;
   end

endmodule
